FILE: src/cpa_pkg.sv
// cpa_pkg: shared types, codes and helpers for the contiguous page allocator
// segment entry layout, request and status codes, controller micro-operations
// no dependencies
`default_nettype none

package cpa_pkg;

  localparam int MAX_PAGES    = 1024;
  localparam int MAX_SEGMENTS = 64;
  localparam int OWNER_BITS   = 16;
  localparam int PAGE_W       = 10;
  localparam int LEN_W        = 11;
  localparam int CTR_W        = 32;

  typedef struct packed {
    logic [OWNER_BITS-1:0] owner;
    logic [PAGE_W-1:0]     start;
    logic [LEN_W-1:0]      len;
    logic                  free;
    logic [CTR_W-1:0]      reads;
    logic [CTR_W-1:0]      writes;
  } seg_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    U_NOP, U_INIT, U_LOAD, U_RD, U_SCAN, U_FAIL, U_RW, U_RST0, U_CEV, U_CEND,
    U_PLACE, U_ISET, U_IEV, U_IEND, U_FEV, U_FEND, U_OUT
  } uop_t;

  typedef struct packed {
    uop_t    uop;
    status_t code;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic found;
    logic no_space;
    logic exact;
    logic full;
    logic again;
    logic at_hi;
    logic range_err;
    logic out_free;
  } sts_t;

  function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] a,
                                               input logic [CTR_W-1:0] b);
    logic [CTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CTR_W] ? {CTR_W{1'b1}} : s[CTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/cpa_datapath.sv
// cpa_datapath: segment table memory, sweep indexes, accumulators, result registers
// executes one micro-operation per cycle from cpa_ctrl; uses cpa_pkg
`default_nettype none

module cpa_datapath #(
  parameter int MAX_SEGMENTS = cpa_pkg::MAX_SEGMENTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [cpa_pkg::LEN_W-1:0]    cfg_wdata,
  input  wire logic [1:0]                   op,
  input  wire logic [15:0]                  owner_id,
  input  wire logic [cpa_pkg::LEN_W-1:0]    page_value,
  input  wire logic                         out_stall,
  input  wire cpa_pkg::cmd_t                cmd,
  output cpa_pkg::sts_t                     sts,
  output logic                              out_valid,
  output logic                              ok,
  output logic [1:0]                        status,
  output logic [cpa_pkg::PAGE_W-1:0]        swap_page,
  output logic                              compacted,
  output logic [31:0]                       read_count,
  output logic [31:0]                       write_count
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  cpa_pkg::seg_t mem [MAX_SEGMENTS];
  cpa_pkg::seg_t rd, cur;
  cpa_pkg::seg_t wd, owned, rem, hole_pend, chole;
  logic          we;
  logic [IW-1:0] wa;

  logic [cpa_pkg::LEN_W-1:0]  tp, freesum, pos, rq_pv, hlen;
  logic [cpa_pkg::PAGE_W-1:0] hstart;
  logic [CW-1:0]              cnt, ri, wi;
  logic [IW-1:0]              hi;
  logic                       found, hv;
  cpa_pkg::op_t               rq_op;
  logic [15:0]                rq_owner;
  logic                       r_ok, r_comp;
  cpa_pkg::status_t           r_status;
  logic [cpa_pkg::PAGE_W-1:0] r_page;
  logic [31:0]                rc, wc;
  logic                       match, is_free, hole_ok, out_free;

  assign match    = !rd.free && (rd.owner == rq_owner);
  assign is_free  = rd.free || match;
  assign hole_ok  = (pos < tp) && (wi < CNT_MAX);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    owned        = cur;
    owned.owner  = rq_owner;
    owned.len    = rq_pv;
    owned.free   = 1'b0;
    owned.reads  = '0;
    owned.writes = '0;
    rem          = rd;
    rem.start    = rd.start + rq_pv[cpa_pkg::PAGE_W-1:0];
    rem.len      = rd.len - rq_pv;
    hole_pend    = '{owner: '0, start: hstart, len: hlen, free: 1'b1, reads: '0, writes: '0};
    chole        = '{owner: '0, start: pos[cpa_pkg::PAGE_W-1:0], len: tp - pos,
                     free: 1'b1, reads: '0, writes: '0};
  end

  // status toward the controller
  always_comb begin
    sts.op        = rq_op;
    sts.last      = ((ri + CW'(1)) == cnt);
    sts.found     = found;
    sts.no_space  = (rq_pv == '0) || (rq_pv > freesum);
    sts.exact     = (cur.len == rq_pv);
    sts.full      = (cnt == CNT_MAX);
    sts.again     = !is_free && hv;
    sts.at_hi     = (ri[IW-1:0] == hi);
    sts.range_err = (rq_pv >= cur.len);
    sts.out_free  = out_free;
  end

  // table write port
  always_comb begin
    we = 1'b0;
    wa = ri[IW-1:0];
    wd = rd;
    case (cmd.uop)
      cpa_pkg::U_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{owner: '0, start: '0, len: tp, free: 1'b1, reads: '0, writes: '0};
      end
      cpa_pkg::U_RW: begin
        we = 1'b1;
        wa = hi;
        wd = cur;
        if (rq_op == cpa_pkg::OP_READ) wd.reads = cpa_pkg::sat_add(cur.reads, 32'd1);
        else wd.writes = cpa_pkg::sat_add(cur.writes, 32'd1);
      end
      cpa_pkg::U_CEV: begin
        we = !rd.free;
        wa = wi[IW-1:0];
        wd.start = pos[cpa_pkg::PAGE_W-1:0];
      end
      cpa_pkg::U_CEND: begin
        we = hole_ok;
        wa = wi[IW-1:0];
        wd = chole;
      end
      cpa_pkg::U_PLACE, cpa_pkg::U_IEND: begin
        we = 1'b1;
        wa = hi;
        wd = owned;
      end
      cpa_pkg::U_IEV: begin
        we = 1'b1;
        wa = ri[IW-1:0] + IW'(1);
        wd = (ri[IW-1:0] == hi) ? rem : rd;
      end
      cpa_pkg::U_FEV: begin
        we = !is_free;
        wa = wi[IW-1:0];
        wd = hv ? hole_pend : rd;
      end
      cpa_pkg::U_FEND: begin
        we = hv;
        wa = wi[IW-1:0];
        wd = hole_pend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.uop == cpa_pkg::U_RD) rd <= mem[ri[IW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tp        <= cpa_pkg::LEN_W'(cpa_pkg::MAX_PAGES);
      cnt       <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) tp <= cpa_pkg::LEN_W'(1);
        else if (cfg_wdata > cpa_pkg::LEN_W'(cpa_pkg::MAX_PAGES))
          tp <= cpa_pkg::LEN_W'(cpa_pkg::MAX_PAGES);
        else tp <= cfg_wdata;
      end
      case (cmd.uop)
        cpa_pkg::U_INIT: cnt <= CW'(1);
        cpa_pkg::U_CEND: cnt <= wi + CW'(hole_ok);
        cpa_pkg::U_IEND: cnt <= cnt + CW'(1);
        cpa_pkg::U_FEND: cnt <= wi + CW'(hv);
        default: ;
      endcase
      if (cmd.uop == cpa_pkg::U_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.uop)
      cpa_pkg::U_LOAD: begin
        rq_op    <= cpa_pkg::op_t'(op);
        rq_owner <= owner_id;
        rq_pv    <= page_value;
        ri       <= '0;
        found    <= 1'b0;
        freesum  <= '0;
        r_ok     <= 1'b0;
        r_status <= cpa_pkg::ST_OK;
        r_page   <= '0;
        r_comp   <= 1'b0;
        rc       <= '0;
        wc       <= '0;
      end
      cpa_pkg::U_SCAN: begin
        if (rq_op == cpa_pkg::OP_ALLOC) begin
          if (rd.free) freesum <= freesum + rd.len;
          if (!found && rd.free && rd.len >= rq_pv) begin
            found <= 1'b1;
            hi    <= ri[IW-1:0];
            cur   <= rd;
          end
        end else if (!found && match) begin
          found <= 1'b1;
          hi    <= ri[IW-1:0];
          cur   <= rd;
        end
        ri <= ri + CW'(1);
      end
      cpa_pkg::U_FAIL: r_status <= cmd.code;
      cpa_pkg::U_RW: begin
        r_ok   <= 1'b1;
        r_page <= cur.start + rq_pv[cpa_pkg::PAGE_W-1:0];
      end
      cpa_pkg::U_RST0: begin
        ri  <= '0;
        wi  <= '0;
        pos <= '0;
        hv  <= 1'b0;
      end
      cpa_pkg::U_CEV: begin
        if (!rd.free) begin
          wi  <= wi + CW'(1);
          pos <= pos + rd.len;
        end
        ri <= ri + CW'(1);
      end
      cpa_pkg::U_CEND: begin
        r_comp <= 1'b1;
        found  <= hole_ok;
        hi     <= wi[IW-1:0];
        cur    <= chole;
      end
      cpa_pkg::U_PLACE, cpa_pkg::U_IEND: begin
        r_ok   <= 1'b1;
        r_page <= cur.start;
      end
      cpa_pkg::U_ISET: ri <= cnt - CW'(1);
      cpa_pkg::U_IEV: if (ri[IW-1:0] != hi) ri <= ri - CW'(1);
      cpa_pkg::U_FEV: begin
        if (match) begin
          rc <= cpa_pkg::sat_add(rc, rd.reads);
          wc <= cpa_pkg::sat_add(wc, rd.writes);
        end
        if (is_free) begin
          if (rd.len != '0) begin
            if (hv) hlen <= hlen + rd.len;
            else begin
              hv     <= 1'b1;
              hstart <= rd.start;
              hlen   <= rd.len;
            end
          end
          ri <= ri + CW'(1);
        end else if (hv) begin
          // pending hole goes first, owned entry is written next cycle
          wi <= wi + CW'(1);
          hv <= 1'b0;
        end else begin
          wi <= wi + CW'(1);
          ri <= ri + CW'(1);
        end
      end
      cpa_pkg::U_FEND: r_ok <= 1'b1;
      cpa_pkg::U_OUT: begin
        ok          <= r_ok;
        status      <= r_status;
        swap_page   <= r_page;
        compacted   <= r_comp;
        read_count  <= rc;
        write_count <= wc;
      end
      default: ;
    endcase
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (cnt <= CNT_MAX))
    else $error("segment count out of range");

  a_wi_behind: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == cpa_pkg::U_CEV || cmd.uop == cpa_pkg::U_FEV) |-> (wi <= ri))
    else $error("in-place rewrite overtook read index");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == cpa_pkg::U_OUT) |-> out_free)
    else $error("result loaded over an untaken result");

  a_freesum: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == cpa_pkg::U_SCAN) |-> (freesum <= tp))
    else $error("free space exceeds managed pages");

endmodule

`default_nettype wire

FILE: src/cpa_ctrl.sv
// cpa_ctrl: request sequencer for the contiguous page allocator
// steps scan, compaction, insert and free sweeps; uses cpa_pkg
`default_nettype none

module cpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          cfg_we,
  input  wire cpa_pkg::sts_t sts,
  output logic               in_stall,
  output cpa_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SRD, S_SEV, S_SDEC, S_CRD, S_CEV, S_CEND, S_PCHK,
    S_IRD, S_IEV, S_IEND, S_FRD, S_FEV, S_FEND, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '{uop: cpa_pkg::U_NOP, code: cpa_pkg::ST_OK};
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.uop    = cpa_pkg::U_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop    = cpa_pkg::U_LOAD;
          state_next = S_SRD;
        end else if (cfg_we) state_next = S_INIT;
      end
      S_SRD: begin
        cmd.uop    = cpa_pkg::U_RD;
        state_next = S_SEV;
      end
      S_SEV: begin
        cmd.uop    = cpa_pkg::U_SCAN;
        state_next = sts.last ? S_SDEC : S_SRD;
      end
      S_SDEC: begin
        state_next = S_DONE;
        case (sts.op)
          cpa_pkg::OP_ALLOC: begin
            if (sts.no_space) begin
              cmd = '{uop: cpa_pkg::U_FAIL, code: cpa_pkg::ST_NO_SPACE};
            end else if (sts.found) state_next = S_PCHK;
            else begin
              cmd.uop    = cpa_pkg::U_RST0;
              state_next = S_CRD;
            end
          end
          cpa_pkg::OP_FREE: begin
            if (!sts.found) cmd = '{uop: cpa_pkg::U_FAIL, code: cpa_pkg::ST_NO_OWNER};
            else begin
              cmd.uop    = cpa_pkg::U_RST0;
              state_next = S_FRD;
            end
          end
          default: begin
            if (!sts.found) cmd = '{uop: cpa_pkg::U_FAIL, code: cpa_pkg::ST_NO_OWNER};
            else if (sts.range_err) cmd = '{uop: cpa_pkg::U_FAIL, code: cpa_pkg::ST_RANGE};
            else cmd.uop = cpa_pkg::U_RW;
          end
        endcase
      end
      S_CRD: begin
        cmd.uop    = cpa_pkg::U_RD;
        state_next = S_CEV;
      end
      S_CEV: begin
        cmd.uop    = cpa_pkg::U_CEV;
        state_next = sts.last ? S_CEND : S_CRD;
      end
      S_CEND: begin
        cmd.uop    = cpa_pkg::U_CEND;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        state_next = S_DONE;
        if (!sts.found || (!sts.exact && sts.full)) begin
          cmd = '{uop: cpa_pkg::U_FAIL, code: cpa_pkg::ST_NO_SPACE};
        end else if (sts.exact) cmd.uop = cpa_pkg::U_PLACE;
        else begin
          cmd.uop    = cpa_pkg::U_ISET;
          state_next = S_IRD;
        end
      end
      S_IRD: begin
        cmd.uop    = cpa_pkg::U_RD;
        state_next = S_IEV;
      end
      S_IEV: begin
        cmd.uop    = cpa_pkg::U_IEV;
        state_next = sts.at_hi ? S_IEND : S_IRD;
      end
      S_IEND: begin
        cmd.uop    = cpa_pkg::U_IEND;
        state_next = S_DONE;
      end
      S_FRD: begin
        cmd.uop    = cpa_pkg::U_RD;
        state_next = S_FEV;
      end
      S_FEV: begin
        cmd.uop = cpa_pkg::U_FEV;
        if (sts.again) state_next = S_FEV;
        else state_next = sts.last ? S_FEND : S_FRD;
      end
      S_FEND: begin
        cmd.uop    = cpa_pkg::U_FEND;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.uop    = cpa_pkg::U_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

endmodule

`default_nettype wire

FILE: src/contiguous_page_allocator.sv
// contiguous_page_allocator: top level of the first-fit page allocator with compaction
// joins cpa_ctrl (sequencer) and cpa_datapath (segment table); uses cpa_pkg
//
//   channel   direction  handshake            payload
//   config    in         cfg_we               cfg_wdata (total_pages)
//   request   in         in_valid / in_stall  op, owner_id, page_value
//   result    out        out_valid/out_stall  ok, status, swap_page, compacted,
//                                             read_count, write_count
//
// one request at a time; the segment table is swept one entry at a time, each entry
//   read through its single read port and then evaluated
// allocate may add a compaction sweep and an insert shift sweep; free adds a
//   merge pass that may revisit an entry to write a pending hole first
// reset, and a total_pages write taken in IDLE with no request waiting, rebuild entry 0
// a finished result sits in the output register while the next request is
//   taken; the block only holds in DONE if that register is still occupied
`default_nettype none

module contiguous_page_allocator #(
  parameter int MAX_SEGMENTS = cpa_pkg::MAX_SEGMENTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] owner_id,
  input  wire logic [10:0] page_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [1:0]       status,
  output logic [9:0]       swap_page,
  output logic             compacted,
  output logic [31:0]      read_count,
  output logic [31:0]      write_count
);

  // micro-op command and sweep status between sequencer and datapath
  cpa_pkg::cmd_t cmd;
  cpa_pkg::sts_t sts;

  cpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // table memory, sweep indexes, accumulators and the result register
  cpa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .op          (op),
    .owner_id    (owner_id),
    .page_value  (page_value),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .ok          (ok),
    .status      (status),
    .swap_page   (swap_page),
    .compacted   (compacted),
    .read_count  (read_count),
    .write_count (write_count)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for contiguous_page_allocator
// drives requests and total_pages writes, predicts each result with a segment-table model
// depends on cpa_pkg and contiguous_page_allocator
`timescale 1ns / 1ps

module tb_top;

  localparam int SEG_MAX   = cpa_pkg::MAX_SEGMENTS;
  localparam int PAGE_MAX  = cpa_pkg::MAX_PAGES;
  localparam int IDLE_LIM  = 20000;

  // one predicted result
  typedef struct {
    logic             ok;
    cpa_pkg::status_t status;
    logic [9:0]       swap_page;
    logic             compacted;
    logic [31:0]      read_count;
    logic [31:0]      write_count;
  } alloc_result_t;

  // one directed row; has_exp marks rows whose result is typed in
  typedef struct {
    cpa_pkg::op_t     op;
    logic [15:0]      owner;
    logic [10:0]      pv;
    logic             has_exp;
    logic             x_ok;
    cpa_pkg::status_t x_status;
    logic [9:0]       x_page;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [15:0] owner_id = '0;
  logic [10:0] page_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic [1:0] status;
  logic [9:0] swap_page;
  logic compacted;
  logic [31:0] read_count, write_count;

  always #10 clk = ~clk;

  contiguous_page_allocator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .owner_id(owner_id),
    .page_value(page_value), .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .status(status), .swap_page(swap_page), .compacted(compacted),
    .read_count(read_count), .write_count(write_count)
  );

  // shadow segment table
  int unsigned pages_total;
  logic [15:0] t_owner[SEG_MAX];
  int unsigned t_start[SEG_MAX];
  int unsigned t_len[SEG_MAX];
  bit          t_free[SEG_MAX];
  logic [31:0] t_rd[SEG_MAX];
  logic [31:0] t_wr[SEG_MAX];
  int unsigned t_n;

  alloc_result_t pending_results[$];
  int  fail_count = 0;
  bit  no_idle = 1'b0;
  int  idle_cycles = 0;
  logic [15:0] live_owners[$];

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void table_restart(int unsigned value);
    value = value & 11'h7FF;
    if (value == 0) value = 1;
    if (value > PAGE_MAX) value = PAGE_MAX;
    pages_total = value;
    for (int k = 0; k < SEG_MAX; k++) begin
      t_owner[k] = '0; t_start[k] = 0; t_len[k] = 0; t_free[k] = 0;
      t_rd[k] = '0; t_wr[k] = '0;
    end
    t_free[0] = 1; t_len[0] = pages_total; t_n = 1;
  endfunction

  function automatic void move_entry(int d, int s);
    t_owner[d] = t_owner[s]; t_start[d] = t_start[s]; t_len[d] = t_len[s];
    t_free[d] = t_free[s]; t_rd[d] = t_rd[s]; t_wr[d] = t_wr[s];
  endfunction

  function automatic void drop_entry(int i);
    for (int k = i; k + 1 < t_n; k++) move_entry(k, k + 1);
    t_n--;
  endfunction

  function automatic int hole_for(int unsigned need);
    for (int i = 0; i < t_n; i++)
      if (t_free[i] && t_len[i] >= need) return i;
    return t_n;
  endfunction

  function automatic int owner_slot(logic [15:0] o);
    for (int i = 0; i < t_n; i++)
      if (!t_free[i] && t_owner[i] == o) return i;
    return t_n;
  endfunction

  // compaction: owned runs slide down in table order, at most one hole at the top
  function automatic void squeeze_table();
    int n;
    int unsigned pos;
    n = 0; pos = 0;
    for (int i = 0; i < t_n; i++)
      if (!t_free[i]) begin
        move_entry(n, i);
        t_start[n] = pos;
        pos += t_len[n];
        n++;
      end
    t_n = n;
    if (pos < pages_total && n < SEG_MAX) begin
      t_owner[n] = '0; t_start[n] = pos; t_len[n] = pages_total - pos;
      t_free[n] = 1; t_rd[n] = '0; t_wr[n] = '0; t_n = n + 1;
    end
  endfunction

  // works out the result of one request and updates the shadow table
  function automatic alloc_result_t predict_request(cpa_pkg::op_t rop, logic [15:0] o,
                                                     logic [10:0] pv);
    alloc_result_t r;
    int unsigned freesum;
    int h, i;
    r = '{ok: 0, status: cpa_pkg::ST_OK, swap_page: '0, compacted: 0,
          read_count: '0, write_count: '0};
    case (rop)
      cpa_pkg::OP_ALLOC: begin
        freesum = 0;
        for (i = 0; i < t_n; i++) if (t_free[i]) freesum += t_len[i];
        if (pv == 0 || pv > freesum) r.status = cpa_pkg::ST_NO_SPACE;
        else begin
          h = hole_for(pv);
          if (h >= t_n) begin
            squeeze_table();
            r.compacted = 1;
            h = hole_for(pv);
          end
          if (h >= t_n) r.status = cpa_pkg::ST_NO_SPACE;
          else if (t_len[h] == pv) begin
            t_free[h] = 0; t_owner[h] = o; t_rd[h] = '0; t_wr[h] = '0;
            r.swap_page = 10'(t_start[h]); r.ok = 1;
          end else if (t_n >= SEG_MAX) r.status = cpa_pkg::ST_NO_SPACE;
          else begin
            for (int k = t_n; k > h; k--) move_entry(k, k - 1);
            t_n++;
            t_free[h] = 0; t_owner[h] = o; t_len[h] = pv;
            t_rd[h] = '0; t_wr[h] = '0;
            t_start[h + 1] += pv; t_len[h + 1] -= pv;
            r.swap_page = 10'(t_start[h]); r.ok = 1;
          end
        end
      end
      cpa_pkg::OP_FREE: begin
        if (owner_slot(o) >= t_n) r.status = cpa_pkg::ST_NO_OWNER;
        else begin
          for (i = 0; i < t_n; i++)
            if (!t_free[i] && t_owner[i] == o) begin
              r.read_count = add_sat(r.read_count, t_rd[i]);
              r.write_count = add_sat(r.write_count, t_wr[i]);
              t_free[i] = 1; t_rd[i] = '0; t_wr[i] = '0;
            end
          // merge neighbouring holes, drop empty ones
          i = 0;
          while (i < t_n) begin
            if (t_free[i] && t_len[i] == 0) drop_entry(i);
            else if (t_free[i] && i + 1 < t_n && t_free[i + 1]) begin
              t_len[i] += t_len[i + 1];
              drop_entry(i + 1);
            end else i++;
          end
          r.ok = 1;
        end
      end
      default: begin
        i = owner_slot(o);
        if (i >= t_n) r.status = cpa_pkg::ST_NO_OWNER;
        else if (pv >= t_len[i]) r.status = cpa_pkg::ST_RANGE;
        else begin
          r.swap_page = 10'(t_start[i] + pv);
          if (rop == cpa_pkg::OP_READ) t_rd[i] = add_sat(t_rd[i], 32'd1);
          else t_wr[i] = add_sat(t_wr[i], 32'd1);
          r.ok = 1;
        end
      end
    endcase
    return r;
  endfunction

  // one request transfer, with a random gap before it
  task automatic send_request(cpa_pkg::op_t rop, logic [15:0] o, logic [10:0] pv);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 30) @(negedge clk);
    op <= rop; owner_id <= o; page_value <= pv; in_valid <= 1'b1;
    pending_results.push_back(predict_request(rop, o, pv));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // register write while idle; the table restarts
  task automatic set_total_pages(logic [10:0] value);
    drain_results();
    cfg_wdata <= value; cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    table_restart(value);
    live_owners.delete();
    repeat (4) @(negedge clk);
  endtask

  // result stall generator
  always @(negedge clk)
    out_stall <= !no_idle && ($urandom_range(99) < 30);

  // result check at the rising edge
  always @(posedge clk) begin
    alloc_result_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        fail_count++;
      end else begin
        x = pending_results.pop_front();
        if (ok !== x.ok) begin
          $error("ok: expected %0d actual %0d", x.ok, ok); fail_count++;
        end
        if (status !== x.status) begin
          $error("status: expected %0d actual %0d", x.status, status); fail_count++;
        end
        if (swap_page !== x.swap_page) begin
          $error("swap_page: expected %0d actual %0d", x.swap_page, swap_page);
          fail_count++;
        end
        if (compacted !== x.compacted) begin
          $error("compacted: expected %0d actual %0d", x.compacted, compacted);
          fail_count++;
        end
        if (read_count !== x.read_count) begin
          $error("read_count: expected %0d actual %0d", x.read_count, read_count);
          fail_count++;
        end
        if (write_count !== x.write_count) begin
          $error("write_count: expected %0d actual %0d", x.write_count, write_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else if (pending_results.size() != 0 || in_valid) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // directed rows; typed-in results only where obvious
  dir_row_t dir_rows[] = '{
    '{cpa_pkg::OP_READ,  16'h0000, 11'd0,    1, 0, cpa_pkg::ST_NO_OWNER, 10'd0},
    '{cpa_pkg::OP_FREE,  16'hFFFF, 11'd0,    1, 0, cpa_pkg::ST_NO_OWNER, 10'd0},
    '{cpa_pkg::OP_ALLOC, 16'h0001, 11'd0,    1, 0, cpa_pkg::ST_NO_SPACE, 10'd0},
    '{cpa_pkg::OP_ALLOC, 16'h0001, 11'd1025, 1, 0, cpa_pkg::ST_NO_SPACE, 10'd0},
    '{cpa_pkg::OP_ALLOC, 16'hFFFF, 11'd1,    1, 1, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_ALLOC, 16'h0002, 11'd100,  1, 1, cpa_pkg::ST_OK,       10'd1},
    '{cpa_pkg::OP_WRITE, 16'h0002, 11'd99,   1, 1, cpa_pkg::ST_OK,       10'd100},
    '{cpa_pkg::OP_READ,  16'h0002, 11'd100,  1, 0, cpa_pkg::ST_RANGE,    10'd0},
    '{cpa_pkg::OP_READ,  16'hFFFF, 11'd2047, 1, 0, cpa_pkg::ST_RANGE,    10'd0},
    '{cpa_pkg::OP_ALLOC, 16'h0002, 11'd10,   0, 0, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_READ,  16'h0002, 11'd0,    0, 0, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_FREE,  16'hFFFF, 11'd0,    0, 0, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_FREE,  16'h0002, 11'd555,  0, 0, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_ALLOC, 16'h0003, 11'd1024, 0, 0, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_READ,  16'h0003, 11'd1023, 0, 0, cpa_pkg::ST_OK,       10'd0},
    '{cpa_pkg::OP_FREE,  16'h0003, 11'd0,    0, 0, cpa_pkg::ST_OK,       10'd0}
  };

  // random request mostly aimed at live owners
  task automatic random_request();
    int sel, pick;
    logic [15:0] o;
    logic [10:0] pv;
    sel = $urandom_range(99);
    if (live_owners.size() != 0 && $urandom_range(99) < 80)
      o = live_owners[$urandom_range(live_owners.size() - 1)];
    else o = 16'($urandom);
    if (sel < 35) begin
      pick = $urandom_range(99);
      if (pick < 80) pv = 11'($urandom_range(1, (pages_total / 8) + 1));
      else if (pick < 95) pv = 11'($urandom_range(0, pages_total + 1));
      else pv = 11'($urandom);
      o = (live_owners.size() < 20 || $urandom_range(1)) ? 16'($urandom) : o;
      send_request(cpa_pkg::OP_ALLOC, o, pv);
      if (pending_results[$].ok) live_owners.push_back(o);
    end else if (sel < 50) begin
      send_request(cpa_pkg::OP_FREE, o, 11'($urandom));
      for (int k = live_owners.size() - 1; k >= 0; k--)
        if (live_owners[k] == o) live_owners.delete(k);
    end else begin
      pv = ($urandom_range(99) < 85) ? 11'($urandom_range(0, 40)) : 11'($urandom);
      send_request($urandom_range(1) ? cpa_pkg::OP_READ : cpa_pkg::OP_WRITE, o, pv);
    end
  endtask

  initial begin
    alloc_result_t x;
    logic [10:0] sizes[4];
    table_restart(1024);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset size
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].owner, dir_rows[i].pv);
      if (dir_rows[i].has_exp) begin
        x = pending_results[$];
        if (x.ok !== dir_rows[i].x_ok || x.status !== dir_rows[i].x_status ||
            x.swap_page !== dir_rows[i].x_page) begin
          $error("directed row %0d: typed result disagrees with prediction", i);
          fail_count++;
        end
      end
    end

    // fill the table to its segment limit, then ask for a split
    set_total_pages(11'd200);
    for (int k = 0; k < 70; k++) send_request(cpa_pkg::OP_ALLOC, 16'(k + 16'h100), 11'd1);
    send_request(cpa_pkg::OP_ALLOC, 16'h0777, 11'd2);
    for (int k = 0; k < 64; k += 2) send_request(cpa_pkg::OP_FREE, 16'(k + 16'h100), 11'd0);
    send_request(cpa_pkg::OP_ALLOC, 16'h0888, 11'd40);

    // register extremes including out-of-range codes
    sizes = '{11'd0, 11'd1, 11'd2047, 11'd64};
    foreach (sizes[s]) begin
      set_total_pages(sizes[s]);
      send_request(cpa_pkg::OP_ALLOC, 16'h0042, 11'd1);
      send_request(cpa_pkg::OP_ALLOC, 16'h0043, 11'd1);
      send_request(cpa_pkg::OP_WRITE, 16'h0042, 11'd0);
      send_request(cpa_pkg::OP_FREE, 16'h0042, 11'd0);
    end

    // random phases over several sizes, one stretch with no idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_total_pages(11'd1024);
        1: set_total_pages(11'($urandom_range(1, 1024)));
        2: set_total_pages(11'd48);
        3: set_total_pages(11'd1);
        default: set_total_pages(11'd300);
      endcase
      no_idle = (phase == 2);
      for (int k = 0; k < 245; k++) random_request();
    end
    no_idle = 1'b0;

    drain_results();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
